// ===== hdl/sti_pkg.sv =====
// Package for the sorted table linear interpolator.
// Holds the table depth default, item kind codes, controller states,
// datapath operations and the status struct. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sti_pkg;

   localparam int TABLE_DEPTH = 256;

   localparam logic [1:0] KIND_CLEAR = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LD_CHK,
      ST_LD_CMP,
      ST_Q_RD,
      ST_Q_CMP,
      ST_MUL,
      ST_DIV,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_LD_INIT,
      OP_LD_RD,
      OP_LD_SHIFT,
      OP_LD_PUT,
      OP_Q_INIT,
      OP_Q_RD,
      OP_Q_ADV,
      OP_Q_HIT,
      OP_MUL,
      OP_DIV,
      OP_EMIT_ZERO,
      OP_EMIT_RES
   } op_type;

   typedef struct packed {
      logic full;
      logic lt_two;
      logic idx_zero;
      logic idx_at_count;
      logic x_above;
      logic x_tie;
      logic mul_last;
      logic div_last;
   } status_type;

endpackage
`default_nettype wire

// ===== hdl/sti_datapath.sv =====
// Datapath: point memory, scan index, shift-add multiplier, restoring divider
// and result register. Driven by op codes from sti_controller; uses sti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sti_datapath #(
   parameter int TableDepth = sti_pkg::TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire sti_pkg::op_type    op,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_query_x,
   output sti_pkg::status_type     status,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_interp_value,
   output logic                    rsp_in_range
);
   localparam int CW = $clog2(TableDepth + 1);
   localparam int AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;

   logic [63:0] mem [TableDepth];

   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic signed [31:0] opx_ff, opx_in, opy_ff, opy_in;
   logic [63:0] rd_ff;
   logic signed [31:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in, yl_ff, yl_in;
   logic [31:0] mag_ff, mag_in, dx_ff, dx_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        valid_ff, valid_in, range_ff, range_in;
   logic signed [31:0] value_ff, value_in;

   logic signed [31:0] rd_x, rd_y;
   logic [CW-1:0] idx_dec;
   logic [AW-1:0] raddr, waddr;
   logic [63:0]   wdata;
   logic          wen, ren;
   logic signed [32:0] dy;
   logic [32:0] dx_w, dq_w, sum, rem_sh;
   logic        ge;
   logic signed [33:0] res;

   assign rd_x    = rd_ff[63:32];
   assign rd_y    = rd_ff[31:0];
   assign idx_dec = idx_ff - CW'(1);

   // memory ports
   always_comb begin
      wen   = (op == sti_pkg::OP_LD_SHIFT) || (op == sti_pkg::OP_LD_PUT);
      ren   = (op == sti_pkg::OP_LD_RD) || (op == sti_pkg::OP_Q_RD);
      waddr = idx_ff[AW-1:0];
      wdata = (op == sti_pkg::OP_LD_SHIFT) ? rd_ff : {opx_ff, opy_ff};
      raddr = (op == sti_pkg::OP_LD_RD) ? idx_dec[AW-1:0] : idx_ff[AW-1:0];
   end

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      if (ren) begin
         rd_ff <= mem[raddr];
      end
   end

   // arithmetic
   always_comb begin
      dy     = 33'(rd_y) - 33'(prev_y_ff);
      dx_w   = 33'(rd_x) - 33'(prev_x_ff);
      dq_w   = 33'(opx_ff) - 33'(prev_x_ff);
      sum    = {1'b0, prod_ff[63:32]} + (prod_ff[0] ? {1'b0, mag_ff} : 33'd0);
      rem_sh = {rem_ff, prod_ff[63]};
      ge     = rem_sh >= {1'b0, dx_ff};
      res    = neg_ff ? 34'(yl_ff) - 34'(prod_ff[32:0])
                      : 34'(yl_ff) + 34'(prod_ff[32:0]);
   end

   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      opx_in    = opx_ff;
      opy_in    = opy_ff;
      prev_x_in = prev_x_ff;
      prev_y_in = prev_y_ff;
      yl_in     = yl_ff;
      mag_in    = mag_ff;
      dx_in     = dx_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      valid_in  = 1'b0;
      range_in  = 1'b0;
      value_in  = value_ff;
      unique case (op)
         sti_pkg::OP_CLEAR: begin
            count_in = '0;
         end
         sti_pkg::OP_LD_INIT: begin
            opx_in = req_point_x;
            opy_in = req_point_y;
            idx_in = count_ff;
         end
         sti_pkg::OP_LD_SHIFT: begin
            idx_in = idx_dec;
         end
         sti_pkg::OP_LD_PUT: begin
            count_in = count_ff + CW'(1);
         end
         sti_pkg::OP_Q_INIT: begin
            opx_in = req_query_x;
            idx_in = '0;
         end
         sti_pkg::OP_Q_ADV: begin
            prev_x_in = rd_x;
            prev_y_in = rd_y;
            idx_in    = idx_ff + CW'(1);
         end
         sti_pkg::OP_Q_HIT: begin
            neg_in  = dy[32];
            mag_in  = dy[32] ? 32'(-dy) : dy[31:0];
            dx_in   = dx_w[31:0];
            prod_in = {32'd0, dq_w[31:0]};
            yl_in   = prev_y_ff;
            rem_in  = '0;
            cnt_in  = '0;
         end
         sti_pkg::OP_MUL: begin
            prod_in = {sum, prod_ff[31:1]};
            cnt_in  = status.mul_last ? 6'd0 : cnt_ff + 6'd1;
         end
         sti_pkg::OP_DIV: begin
            prod_in = {prod_ff[62:0], ge};
            rem_in  = ge ? 32'(rem_sh - {1'b0, dx_ff}) : rem_sh[31:0];
            cnt_in  = cnt_ff + 6'd1;
         end
         sti_pkg::OP_EMIT_ZERO: begin
            valid_in = 1'b1;
            value_in = '0;
         end
         sti_pkg::OP_EMIT_RES: begin
            valid_in = 1'b1;
            range_in = 1'b1;
            if (res[33:31] == 3'b000 || res[33:31] == 3'b111) begin
               value_in = res[31:0];
            end else begin
               value_in = res[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
         range_ff <= 1'b0;
         value_ff <= '0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
         range_ff <= range_in;
         value_ff <= value_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      opx_ff    <= opx_in;
      opy_ff    <= opy_in;
      prev_x_ff <= prev_x_in;
      prev_y_ff <= prev_y_in;
      yl_ff     <= yl_in;
      mag_ff    <= mag_in;
      dx_ff     <= dx_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      neg_ff    <= neg_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      status.full         = count_ff >= CW'(TableDepth);
      status.lt_two       = count_ff < CW'(2);
      status.idx_zero     = idx_ff == '0;
      status.idx_at_count = idx_ff == count_ff;
      status.x_above      = rd_x > opx_ff;
      status.x_tie        = rd_x == prev_x_ff;
      status.mul_last     = cnt_ff == 6'd31;
      status.div_last     = cnt_ff == 6'd63;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_in_range     = range_ff;
   assign rsp_interp_value = value_ff;
endmodule
`default_nettype wire

// ===== hdl/sti_controller.sv =====
// Controller state machine: sequences loads, queries, multiply and divide.
// Emits one op code per cycle to sti_datapath; uses sti_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sti_controller (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [1:0]          req_kind,
   input  wire sti_pkg::status_type status,
   output sti_pkg::op_type          op,
   output logic                     busy
);
   sti_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sti_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sti_pkg::ST_IDLE: begin
            if (start && req_kind == sti_pkg::KIND_LOAD && !status.full) begin
               state_in = sti_pkg::ST_LD_CHK;
            end else if (start && req_kind == sti_pkg::KIND_QUERY) begin
               state_in = sti_pkg::ST_Q_RD;
            end
         end
         sti_pkg::ST_LD_CHK:
            state_in = status.idx_zero ? sti_pkg::ST_IDLE : sti_pkg::ST_LD_CMP;
         sti_pkg::ST_LD_CMP:
            state_in = status.x_above ? sti_pkg::ST_LD_CHK : sti_pkg::ST_IDLE;
         sti_pkg::ST_Q_RD:
            state_in = (status.lt_two || status.idx_at_count) ? sti_pkg::ST_IDLE
                                                               : sti_pkg::ST_Q_CMP;
         sti_pkg::ST_Q_CMP: begin
            priority if (!status.x_above) begin
               state_in = sti_pkg::ST_Q_RD;
            end else if (status.idx_zero || status.x_tie) begin
               state_in = sti_pkg::ST_IDLE;
            end else begin
               state_in = sti_pkg::ST_MUL;
            end
         end
         sti_pkg::ST_MUL:
            if (status.mul_last) begin
               state_in = sti_pkg::ST_DIV;
            end
         sti_pkg::ST_DIV:
            if (status.div_last) begin
               state_in = sti_pkg::ST_FIN;
            end
         sti_pkg::ST_FIN:
            state_in = sti_pkg::ST_IDLE;
         default:
            state_in = sti_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      op = sti_pkg::OP_NONE;
      unique case (state_ff)
         sti_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_kind)
                  sti_pkg::KIND_CLEAR: op = sti_pkg::OP_CLEAR;
                  sti_pkg::KIND_LOAD:
                     op = status.full ? sti_pkg::OP_NONE : sti_pkg::OP_LD_INIT;
                  sti_pkg::KIND_QUERY: op = sti_pkg::OP_Q_INIT;
                  default: op = sti_pkg::OP_NONE;
               endcase
            end
         end
         sti_pkg::ST_LD_CHK:
            op = status.idx_zero ? sti_pkg::OP_LD_PUT : sti_pkg::OP_LD_RD;
         sti_pkg::ST_LD_CMP:
            op = status.x_above ? sti_pkg::OP_LD_SHIFT : sti_pkg::OP_LD_PUT;
         sti_pkg::ST_Q_RD:
            op = (status.lt_two || status.idx_at_count) ? sti_pkg::OP_EMIT_ZERO
                                                         : sti_pkg::OP_Q_RD;
         sti_pkg::ST_Q_CMP: begin
            priority if (!status.x_above) begin
               op = sti_pkg::OP_Q_ADV;
            end else if (status.idx_zero || status.x_tie) begin
               op = sti_pkg::OP_EMIT_ZERO;
            end else begin
               op = sti_pkg::OP_Q_HIT;
            end
         end
         sti_pkg::ST_MUL: op = sti_pkg::OP_MUL;
         sti_pkg::ST_DIV: op = sti_pkg::OP_DIV;
         sti_pkg::ST_FIN: op = sti_pkg::OP_EMIT_RES;
         default: op = sti_pkg::OP_NONE;
      endcase
   end

   assign busy = state_ff != sti_pkg::ST_IDLE;
endmodule
`default_nettype wire

// ===== hdl/sorted_table_linear_interpolator.sv =====
// Top level of the sorted table linear interpolator.
// Joins sti_controller and sti_datapath; uses sti_pkg.
`timescale 1ns / 1ps
`default_nettype none
// A beat is taken when start is high and busy is low. A clear, and a load
// into a full table, which is dropped, leave busy low. A load walks down
// from the top of the table, moving each larger point up one place with a
// read and then a write through the single-port memory. A query scans up
// from the bottom, reading and then comparing each point visited, then runs
// a 32-step shift-add multiply and a 64-step restoring divide when it hits.
// The result beat appears on the rsp_ ports for exactly one cycle, strobed
// by rsp_valid, in the first cycle that busy is low again; the receiver
// cannot stall, so capture it on that edge. Points with equal x keep load
// order.
module sorted_table_linear_interpolator #(
   parameter int TableDepth = sti_pkg::TABLE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_query_x,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_interp_value,
   output logic                    rsp_in_range
);
   sti_pkg::op_type     op;
   sti_pkg::status_type status;

   // sequence each beat
   sti_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .status   (status),
      .op       (op),
      .busy     (busy)
   );

   // hold the table and do the arithmetic
   sti_datapath #(
      .TableDepth (TableDepth)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .req_point_x      (req_point_x),
      .req_point_y      (req_point_y),
      .req_query_x      (req_query_x),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_interp_value (rsp_interp_value),
      .rsp_in_range     (rsp_in_range)
   );

`ifndef SYNTHESIS
   a_zero_out_of_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_in_range |-> rsp_interp_value == 32'sd0)
      else $error("out-of-range result not zero");

   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without preceding work");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");
`endif
endmodule
`default_nettype wire

// ===== sim/sti_checker.sv =====
// Scoreboard for the sorted table linear interpolator: watches request and
// response beats, keeps its own sorted table and compares each response.
// Depends on sti_pkg for the kind codes.
`timescale 1ns / 1ps
`default_nettype none
module sti_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic [1:0]         req_kind,
   input  wire logic signed [31:0] req_point_x,
   input  wire logic signed [31:0] req_point_y,
   input  wire logic signed [31:0] req_query_x,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_interp_value,
   input  wire logic               rsp_in_range,
   output int                      fail_count,
   output int                      awaited_count
);
   typedef struct packed {
      logic signed [31:0] value;
      logic               in_range;
   } interp_result_type;

   logic signed [31:0] table_x [sti_pkg::TABLE_DEPTH];
   logic signed [31:0] table_y [sti_pkg::TABLE_DEPTH];
   int                 stored;
   interp_result_type  awaited_q [$];

   // index of the first stored x strictly above pos
   function automatic int first_above(logic signed [31:0] pos);
      int i;
      for (i = 0; i < stored; i++)
         if (table_x[i] > pos) return i;
      return stored;
   endfunction

   function automatic void insert_point(logic signed [31:0] px, logic signed [31:0] py);
      int slot;
      if (stored >= sti_pkg::TABLE_DEPTH) return;
      slot = first_above(px);
      for (int i = stored; i > slot; i--) begin
         table_x[i] = table_x[i-1];
         table_y[i] = table_y[i-1];
      end
      table_x[slot] = px;
      table_y[slot] = py;
      stored++;
   endfunction

   function automatic interp_result_type interpolate(logic signed [31:0] pos);
      interp_result_type r;
      int                hi;
      longint            xl, xh, yl, yh, dy, sum;
      bit [63:0]         mag, dq, dx, quo;
      r = '0;
      if (stored < 2) return r;
      hi = first_above(pos);
      if (hi == 0 || hi >= stored) return r;
      xl = table_x[hi-1];
      xh = table_x[hi];
      yl = table_y[hi-1];
      yh = table_y[hi];
      if (xh == xl) return r;
      dy  = yh - yl;
      mag = (dy < 0) ? -dy : dy;
      dq  = longint'(pos) - xl;
      dx  = xh - xl;
      quo = (mag * dq) / dx;
      sum = (dy < 0) ? yl - longint'(quo) : yl + longint'(quo);
      if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
      if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
      r.value    = sum[31:0];
      r.in_range = 1'b1;
      return r;
   endfunction

   assign awaited_count = awaited_q.size();

   always @(posedge clock) begin
      interp_result_type exp_r;
      if (reset) begin
         stored     = 0;
         fail_count = 0;
         awaited_q.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected response value=%0d in_range=%0b",
                           rsp_interp_value, rsp_in_range);
            end else begin
               exp_r = awaited_q.pop_front();
               if (rsp_interp_value !== exp_r.value ||
                   rsp_in_range !== exp_r.in_range) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: expected value=%0d in_range=%0b, got value=%0d in_range=%0b",
                              exp_r.value, exp_r.in_range, rsp_interp_value, rsp_in_range);
               end
            end
         end
         if (start && !busy) begin
            case (req_kind)
               sti_pkg::KIND_CLEAR: stored = 0;
               sti_pkg::KIND_LOAD:  insert_point(req_point_x, req_point_y);
               sti_pkg::KIND_QUERY: awaited_q = {awaited_q, interpolate(req_query_x)};
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ===== sim/tb_sorted_table_linear_interpolator.sv =====
// Testbench top for the sorted table linear interpolator: clock, reset,
// directed and random request beats, verdict. Uses sti_pkg and sti_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_sorted_table_linear_interpolator;
   // spare kind code that the block must ignore
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_kind;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic signed [31:0] req_query_x;
   logic               rsp_valid;
   logic signed [31:0] rsp_interp_value;
   logic               rsp_in_range;
   int                 fail_count;
   int                 awaited_count;

   // abscissas loaded since the last clear, used to aim queries
   logic signed [31:0] loaded_x [$];
   bit                 gaps_on;

   sorted_table_linear_interpolator DUT (
      .clock, .reset, .start, .busy,
      .req_kind, .req_point_x, .req_point_y, .req_query_x,
      .rsp_valid, .rsp_interp_value, .rsp_in_range
   );

   sti_checker checker_i (
      .clock, .reset, .start, .busy,
      .req_kind, .req_point_x, .req_point_y, .req_query_x,
      .rsp_valid, .rsp_interp_value, .rsp_in_range,
      .fail_count, .awaited_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Send one beat: hold start until the block takes it, then maybe idle.
   task automatic send_beat(logic [1:0] kind, logic signed [31:0] px,
                            logic signed [31:0] py, logic signed [31:0] qx);
      int gap;
      start       <= 1'b1;
      req_kind    <= kind;
      req_point_x <= px;
      req_point_y <= py;
      req_query_x <= qx;
      do @(posedge clock); while (busy);
      if (kind == sti_pkg::KIND_CLEAR) loaded_x.delete();
      if (kind == sti_pkg::KIND_LOAD && loaded_x.size() < sti_pkg::TABLE_DEPTH)
         loaded_x = {loaded_x, px};
      gap = gaps_on ? $urandom_range(0, 11) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic load_point(logic signed [31:0] px, logic signed [31:0] py);
      send_beat(sti_pkg::KIND_LOAD, px, py, $urandom);
   endtask

   task automatic query_at(logic signed [31:0] qx);
      send_beat(sti_pkg::KIND_QUERY, $urandom, $urandom, qx);
   endtask

   // Pick a query position near the stored points, or anywhere.
   function automatic logic signed [31:0] aim_query();
      logic signed [31:0] base;
      if (loaded_x.size() == 0 || $urandom_range(0, 9) == 0) return $urandom;
      base = loaded_x[$urandom_range(0, loaded_x.size() - 1)];
      case ($urandom_range(0, 2))
         0: return base;
         1: return base + $signed($urandom_range(0, 8)) - 4;
         default: return base + $signed($urandom_range(0, 32'h3_0000)) - 32'sh1_8000;
      endcase
   endfunction

   // Narrow x range on most loads so that ties and dense segments occur.
   function automatic logic signed [31:0] draw_x();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 15)) - 8;
         default: return $signed($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
      endcase
   endfunction

   initial begin
      int pick;
      int table_cap;
      reset       <= 1'b1;
      start       <= 1'b0;
      req_kind    <= sti_pkg::KIND_CLEAR;
      req_point_x <= '0;
      req_point_y <= '0;
      req_query_x <= '0;
      gaps_on      = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, single point, extremes, ties, spare kind
      query_at(32'sh0);
      load_point(32'sh1_0000, 32'sh7FFF_FFFF);
      query_at(32'sh1_0000);
      load_point(32'sh8000_0000, 32'sh8000_0000);
      load_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      query_at(32'sh8000_0000);
      query_at(32'sh0);
      query_at(32'sh7FFF_FFFE);
      query_at(32'sh7FFF_FFFF);
      send_beat(KIND_SPARE, 32'sh5, 32'sh5, 32'sh5);
      send_beat(sti_pkg::KIND_CLEAR, 32'sh0, 32'sh0, 32'sh0);
      query_at(32'sh0);
      load_point(32'sh2_0000, 32'sh10);
      load_point(32'sh2_0000, -32'sh10);
      load_point(32'sh4_0000, 32'sh7FFF_0000);
      query_at(32'sh1_FFFF);   // below the first x
      query_at(32'sh2_0000);   // lands on the tied pair's upper end
      query_at(32'sh3_0001);
      query_at(32'sh4_0000);   // at the last x

      // fill the table past its depth; the surplus load must be dropped
      send_beat(sti_pkg::KIND_CLEAR, '0, '0, '0);
      gaps_on = 1'b0;
      for (int i = 0; i <= sti_pkg::TABLE_DEPTH; i++) load_point(draw_x(), $urandom);
      gaps_on = 1'b1;
      for (int i = 0; i < 5; i++) query_at(aim_query());
      send_beat(sti_pkg::KIND_CLEAR, '0, '0, '0);

      // random: mostly build-and-query runs on tables of modest size
      table_cap = 16;
      for (int n = 0; n < 900; n++) begin
         if (n % 100 == 0) begin
            gaps_on   = (n % 300 != 0);
            table_cap = ($urandom_range(0, 3) == 0) ? 64 : 16;
         end
         pick = $urandom_range(0, 99);
         if (pick < 3 || loaded_x.size() >= table_cap)
            send_beat(sti_pkg::KIND_CLEAR, $urandom, $urandom, $urandom);
         else if (pick < 5)
            send_beat(KIND_SPARE, $urandom, $urandom, $urandom);
         else if (pick < 45)
            load_point(draw_x(), $urandom);
         else
            query_at(aim_query());
      end
      start <= 1'b0;

      // drain outstanding responses, then watch for strays
      while (awaited_count != 0) @(posedge clock);
      repeat (700) @(posedge clock);
      if (fail_count == 0 && awaited_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #60ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
`default_nettype wire
